### rtl/core/nsps_pkg.sv
// Package for the nearest segment point search block.
// Holds operation codes, the state machine types and shared widths; no dependencies.
package nsps_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_e;

  // Sequencer states of the per-segment evaluation unit.
  typedef enum logic [2:0] {
    E_IDLE,
    E_PROD,
    E_SUM,
    E_DIV,
    E_VEC,
    E_SQ,
    E_DONE
  } eval_state_e;

  localparam int unsigned FracBits = 16;
  localparam int unsigned IndexBits = 10;
  localparam int unsigned ParamBits = 17;

endpackage

### rtl/core/nsps_if.sv
// Valid/ready channel interfaces for the nearest segment point search block.
// Depends on nothing; the input channel widths follow the coordinate width parameter.
interface nsps_in_if #(
  parameter int unsigned CoordBits = 16
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic signed [CoordBits-1:0] ax, ay, az, bx, by, bz, px, py, pz;

  modport source (output valid, operation, ax, ay, az, bx, by, bz, px, py, pz,
                  input ready);
  modport sink   (input valid, operation, ax, ay, az, bx, by, bz, px, py, pz,
                  output ready);
endinterface

interface nsps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [9:0]  segment_index;
  logic [16:0] param;

  modport source (output valid, found, segment_index, param, input ready);
  modport sink   (input valid, found, segment_index, param, output ready);
endinterface

### rtl/core/nsps_div.sv
// Restoring divider giving floor(dot * 2^16 / len2), one quotient bit per cycle.
// Depends on nsps_pkg.
module nsps_div #(
  parameter int unsigned W = 35
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [W-1:0]                 num_i,
  input  logic [W-1:0]                 den_i,
  output logic                         done_o,
  output logic [nsps_pkg::FracBits-1:0] quot_o
);
  localparam int unsigned CntBits = $clog2(nsps_pkg::FracBits + 1);

  logic [W:0]                        rem_q, rem_d;
  logic [W-1:0]                      den_q;
  logic [nsps_pkg::FracBits-1:0]     quot_q, quot_d;
  logic [CntBits-1:0]                cnt_q, cnt_d;
  logic                              busy_q, busy_d;
  logic [W:0]                        shifted;

  // One restoring step per cycle.
  always_comb begin
    shifted = {rem_q[W-1:0], 1'b0};
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d  = shifted - {1'b0, den_q};
        quot_d = {quot_q[nsps_pkg::FracBits-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[nsps_pkg::FracBits-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntBits'(nsps_pkg::FracBits - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = busy_q && (cnt_q == CntBits'(nsps_pkg::FracBits - 1));
  assign quot_o = quot_d;
endmodule

### rtl/core/nsps_eval.sv
// Per-segment evaluation: projection parameter and squared distance, multicycle.
// Depends on nsps_pkg and nsps_div.
module nsps_eval #(
  parameter int unsigned CoordBits = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [3*CoordBits-1:0]   a_i,
  input  logic signed [3*CoordBits-1:0]   b_i,
  input  logic signed [3*CoordBits-1:0]   p_i,
  output logic                            done_o,
  output logic [nsps_pkg::ParamBits-1:0]  param_o,
  output logic [2*CoordBits+2*nsps_pkg::FracBits+5:0] dist_o
);
  localparam int unsigned DW = CoordBits + 1;                    // differences
  localparam int unsigned PW = 2 * DW + 2;                        // dot, len2
  localparam int unsigned VW = DW + nsps_pkg::FracBits + 2;      // scaled vector
  localparam int unsigned SW = 2 * VW + 2;                        // distance sum
  localparam int unsigned DistW = 2 * CoordBits + 2 * nsps_pkg::FracBits + 6;

  nsps_pkg::eval_state_e st_q, st_d;
  logic signed [DW-1:0]   ab_q [3];
  logic signed [DW-1:0]   ap_q [3];
  logic signed [PW-1:0]   pl_q [3];
  logic signed [PW-1:0]   pd_q [3];
  logic signed [PW-1:0]   len2_sum, dot_sum;
  logic [nsps_pkg::ParamBits-1:0] l_q;
  logic signed [VW-1:0]   v_q [3];
  logic [SW-1:0]          sq_q [3];
  logic                   div_start, div_done;
  logic [nsps_pkg::FracBits-1:0] div_quot;

  // Sums of the three registered products, read in the E_SUM state.
  assign len2_sum = pl_q[0] + pl_q[1] + pl_q[2];
  assign dot_sum  = pd_q[0] + pd_q[1] + pd_q[2];

  nsps_div #(.W(PW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i  (dot_sum),
    .den_i  (len2_sum),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign div_start = (st_q == nsps_pkg::E_SUM) && (len2_sum > 0) && (dot_sum > 0)
                     && (dot_sum < len2_sum);

  // Sequencer for one segment.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      nsps_pkg::E_IDLE: if (start_i) st_d = nsps_pkg::E_PROD;
      nsps_pkg::E_PROD: st_d = nsps_pkg::E_SUM;
      nsps_pkg::E_SUM:  st_d = div_start ? nsps_pkg::E_DIV : nsps_pkg::E_VEC;
      nsps_pkg::E_DIV:  if (div_done) st_d = nsps_pkg::E_VEC;
      nsps_pkg::E_VEC:  st_d = nsps_pkg::E_SQ;
      nsps_pkg::E_SQ:   st_d = nsps_pkg::E_DONE;
      nsps_pkg::E_DONE: st_d = nsps_pkg::E_IDLE;
      default: st_d = nsps_pkg::E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= nsps_pkg::E_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Datapath registers, one multiplier level per cycle; they hold while E_DIV waits on the divider.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (st_q == nsps_pkg::E_IDLE && start_i) begin
        ab_q[k] <= DW'($signed(b_i[k*CoordBits +: CoordBits]))
                 - DW'($signed(a_i[k*CoordBits +: CoordBits]));
        ap_q[k] <= DW'($signed(p_i[k*CoordBits +: CoordBits]))
                 - DW'($signed(a_i[k*CoordBits +: CoordBits]));
      end
      if (st_q == nsps_pkg::E_PROD) begin
        pl_q[k] <= PW'(ab_q[k]) * PW'(ab_q[k]);
        pd_q[k] <= PW'(ab_q[k]) * PW'(ap_q[k]);
      end
      if (st_q == nsps_pkg::E_VEC) begin
        v_q[k] <= (VW'(ap_q[k]) <<< nsps_pkg::FracBits)
                - $signed(VW'({1'b0, l_q})) * VW'(ab_q[k]);
      end
      if (st_q == nsps_pkg::E_SQ) begin
        sq_q[k] <= SW'(v_q[k]) * SW'(v_q[k]);
      end
    end
    // Clamped cases are settled here; the divider supplies the rest.
    if (st_q == nsps_pkg::E_SUM) begin
      if (len2_sum <= 0 || dot_sum <= 0) begin
        l_q <= '0;
      end else if (dot_sum >= len2_sum) begin
        l_q <= nsps_pkg::ParamBits'(1) << nsps_pkg::FracBits;
      end
    end
    if (st_q == nsps_pkg::E_DIV && div_done) begin
      l_q <= {1'b0, div_quot};
    end
  end

  assign done_o  = (st_q == nsps_pkg::E_DONE);
  assign param_o = l_q;
  assign dist_o  = DistW'(sq_q[0] + sq_q[1] + sq_q[2]);
endmodule

### rtl/core/nearest_segment_point_search.sv
// Nearest segment point search top level; depends on nsps_pkg, nsps_if and nsps_eval.
// A query holds the input while each stored segment is read and evaluated in turn,
// the divider skipped where none is needed, and until the result word is taken.
// Throughput: one item at a time; the per-segment evaluation unit with its
// 16-step divider sets the query time. Append writes one memory entry per idle cycle.
// Reset: asynchronous active low; empties the table. Memory contents stay undefined.
module nearest_segment_point_search #(
  parameter int unsigned MaxSegments = 1024,
  parameter int unsigned CoordBits   = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  nsps_in_if.sink    in_i,
  nsps_out_if.source out_o
);
  localparam int unsigned AW = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int unsigned CW = $clog2(MaxSegments + 1);
  localparam int unsigned EW = 3 * CoordBits;
  localparam int unsigned DistW = 2 * CoordBits + 2 * nsps_pkg::FracBits + 6;

  // Endpoint memories.
  logic [EW-1:0] mem_a [MaxSegments];
  logic [EW-1:0] mem_b [MaxSegments];
  logic [EW-1:0] rd_a_q, rd_b_q;

  nsps_pkg::state_e st_q, st_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [EW-1:0] p_q;
  logic          have_q, have_d;
  logic [DistW-1:0] best_q, best_d;
  logic [nsps_pkg::IndexBits-1:0] best_i_q, best_i_d;
  logic [nsps_pkg::ParamBits-1:0] best_l_q, best_l_d;
  logic          wr_en, rd_en, ev_start, ev_done;
  logic [nsps_pkg::ParamBits-1:0] ev_param;
  logic [DistW-1:0] ev_dist;
  logic          acc;

  assign in_i.ready = (st_q == nsps_pkg::ST_IDLE);
  assign acc   = in_i.valid && in_i.ready;
  assign wr_en = acc && (in_i.operation == nsps_pkg::OP_APPEND) && (count_q < CW'(MaxSegments));
  assign rd_en = (st_q == nsps_pkg::ST_SCAN);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_a[count_q[AW-1:0]] <= {in_i.az, in_i.ay, in_i.ax};
      mem_b[count_q[AW-1:0]] <= {in_i.bz, in_i.by, in_i.bx};
    end
    if (rd_en) begin
      rd_a_q <= mem_a[idx_q[AW-1:0]];
      rd_b_q <= mem_b[idx_q[AW-1:0]];
    end
  end

  nsps_eval #(.CoordBits(CoordBits)) u_eval (
    .clk_i, .rst_ni,
    .start_i(ev_start),
    .a_i    (rd_a_q),
    .b_i    (rd_b_q),
    .p_i    (p_q),
    .done_o (ev_done),
    .param_o(ev_param),
    .dist_o (ev_dist)
  );

  // ST_SCAN issues a read; ST_DRAIN starts evaluation and waits for it.
  logic drain_start_q;

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      nsps_pkg::ST_IDLE:
        if (acc && in_i.operation == nsps_pkg::OP_QUERY) begin
          st_d = (count_q == '0) ? nsps_pkg::ST_OUT : nsps_pkg::ST_SCAN;
        end
      nsps_pkg::ST_SCAN:  st_d = nsps_pkg::ST_DRAIN;
      nsps_pkg::ST_DRAIN:
        if (ev_done) begin
          st_d = (idx_q + 1'b1 == count_q) ? nsps_pkg::ST_OUT : nsps_pkg::ST_SCAN;
        end
      nsps_pkg::ST_OUT:   if (out_o.ready) st_d = nsps_pkg::ST_IDLE;
      default: st_d = nsps_pkg::ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    count_d  = count_q;
    idx_d    = idx_q;
    have_d   = have_q;
    best_d   = best_q;
    best_i_d = best_i_q;
    best_l_d = best_l_q;
    if (acc && in_i.operation == nsps_pkg::OP_CLEAR) count_d = '0;
    if (wr_en) count_d = count_q + 1'b1;
    if (acc && in_i.operation == nsps_pkg::OP_QUERY) begin
      idx_d  = '0;
      have_d = 1'b0;
      best_i_d = '0;
      best_l_d = '0;
    end
    if (st_q == nsps_pkg::ST_DRAIN && ev_done) begin
      if (!have_q || ev_dist < best_q) begin
        have_d   = 1'b1;
        best_d   = ev_dist;
        best_i_d = nsps_pkg::IndexBits'(idx_q);
        best_l_d = ev_param;
      end
      idx_d = idx_q + 1'b1;
    end
  end

  assign ev_start = drain_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= nsps_pkg::ST_IDLE;
      count_q       <= '0;
      idx_q         <= '0;
      have_q        <= 1'b0;
      drain_start_q <= 1'b0;
    end else begin
      st_q          <= st_d;
      count_q       <= count_d;
      idx_q         <= idx_d;
      have_q        <= have_d;
      drain_start_q <= (st_q == nsps_pkg::ST_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) p_q <= {in_i.pz, in_i.py, in_i.px};
    best_q   <= best_d;
    best_i_q <= best_i_d;
    best_l_q <= best_l_d;
  end

  assign out_o.valid         = (st_q == nsps_pkg::ST_OUT);
  assign out_o.found         = have_q;
  assign out_o.segment_index = have_q ? best_i_q : '0;
  assign out_o.param         = have_q ? best_l_q : '0;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxSegments)) else $error("segment count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != nsps_pkg::ST_IDLE) |-> !in_i.ready) else $error("accept while busy");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == nsps_pkg::ST_SCAN) |-> (idx_q < count_q)) else $error("scan past count");
`endif
endmodule

### tb/nsps_checker.sv
// Checker for the nearest segment point search block: watches both channels,
// predicts each query answer from its own segment table and compares the words.
// Depends on nsps_pkg; it takes the channel signals as plain ports.
`timescale 1ns / 1ps

module nsps_checker #(
  parameter int unsigned MaxSegments = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  operation_i,
  input  logic signed [15:0] ax_i, ay_i, az_i, bx_i, by_i, bz_i, px_i, py_i, pz_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        found_i,
  input  logic [9:0]  segment_index_i,
  input  logic [16:0] param_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          answers_o,
  output int          table_count_o
);
  typedef struct packed {
    logic        found;
    logic [9:0]  segment_index;
    logic [16:0] param;
  } answer_t;

  logic signed [15:0] seg_a [MaxSegments][3];
  logic signed [15:0] seg_b [MaxSegments][3];
  int unsigned seg_count;
  answer_t expected_answers[$];
  int mismatches;

  // Clamped fraction of the projection along a segment, unsigned Q1.16 (0 to 65536).
  function automatic longint fraction_along(longint dot, longint len2);
    longint q;
    if (len2 <= 0 || dot <= 0) return 0;
    if (dot >= len2) return 65536;
    q = (dot * 65536) / len2;
    return q;
  endfunction

  // Exhaustive scan for the first segment with the strictly smallest distance.
  function automatic answer_t nearest_answer(logic signed [15:0] p [3]);
    answer_t ans;
    logic [127:0] best, d;
    longint ab[3], ap[3], len2, dot, l, c;
    ans = '0;
    best = '0;
    for (int i = 0; i < seg_count; i++) begin
      len2 = 0;
      dot = 0;
      for (int k = 0; k < 3; k++) begin
        ab[k] = longint'(seg_b[i][k]) - longint'(seg_a[i][k]);
        ap[k] = longint'(p[k]) - longint'(seg_a[i][k]);
        len2 += ab[k] * ab[k];
        dot += ab[k] * ap[k];
      end
      l = fraction_along(dot, len2);
      d = '0;
      for (int k = 0; k < 3; k++) begin
        c = ap[k] * 65536 - l * ab[k];
        if (c < 0) c = -c;
        d += 128'(c) * 128'(c);
      end
      if (!ans.found || d < best) begin
        ans.found = 1'b1;
        best = d;
        ans.segment_index = i[9:0];
        ans.param = l[16:0];
      end
    end
    return ans;
  endfunction

  assign fail_count_o = mismatches;
  assign table_count_o = seg_count;

  // Update the table on accepted input words and check accepted answers.
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [15:0] p [3];
    answer_t got, want;
    if (!rst_ni) begin
      seg_count <= 0;
      mismatches = 0;
      answers_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        case (nsps_pkg::op_e'(operation_i))
          nsps_pkg::OP_CLEAR: seg_count <= 0;
          nsps_pkg::OP_APPEND: begin
            if (seg_count < MaxSegments) begin
              seg_a[seg_count] = '{ax_i, ay_i, az_i};
              seg_b[seg_count] = '{bx_i, by_i, bz_i};
              seg_count <= seg_count + 1;
            end
          end
          nsps_pkg::OP_QUERY: begin
            p = '{px_i, py_i, pz_i};
            expected_answers.push_back(nearest_answer(p));
          end
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = '{found_i, segment_index_i, param_i};
        answers_o++;
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected answer word %p", got);
        end else begin
          want = expected_answers.pop_front();
          if (got.found !== want.found || got.segment_index !== want.segment_index ||
              got.param !== want.param) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("answer mismatch: expected found=%0d index=%0d param=%0d,",
                       want.found, want.segment_index, want.param);
              $display("  got found=%0d index=%0d param=%0d",
                       got.found, got.segment_index, got.param);
            end
          end
        end
      end
      pending_o = expected_answers.size();
    end
  end
endmodule

### tb/tb_nearest_segment_point_search.sv
// Testbench top for nearest_segment_point_search: drives clear, append, query and
// unused-code words with random idling and gives the verdict. Depends on nsps_pkg,
// nsps_if.sv, nsps_checker.sv and the design itself.
`timescale 1ns / 1ps

module tb_nearest_segment_point_search;
  localparam int unsigned MaxSegments = 256;
  localparam int WatchdogLimit = 200000;

  logic clk_i;
  logic rst_ni;
  logic idle_enable;
  int fail_count, pending, answers, table_count, stall_cycles, words_sent;

  nsps_in_if #(.CoordBits(16)) in_ch ();
  nsps_out_if out_ch ();

  nearest_segment_point_search #(.MaxSegments(MaxSegments), .CoordBits(16)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  nsps_checker #(.MaxSegments(MaxSegments)) u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready), .operation_i(in_ch.operation),
    .ax_i(in_ch.ax), .ay_i(in_ch.ay), .az_i(in_ch.az),
    .bx_i(in_ch.bx), .by_i(in_ch.by), .bz_i(in_ch.bz),
    .px_i(in_ch.px), .py_i(in_ch.py), .pz_i(in_ch.pz),
    .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready), .found_i(out_ch.found),
    .segment_index_i(out_ch.segment_index), .param_i(out_ch.param),
    .fail_count_o(fail_count), .pending_o(pending), .answers_o(answers),
    .table_count_o(table_count)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic logic chance_idle();
    return idle_enable && ($urandom_range(99) < 32);
  endfunction

  // Result side: random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !chance_idle();
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
        $display("tb_nearest_segment_point_search failed");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one word, with a random gap first, and hold it until accepted.
  // Valid stays high after acceptance so that words can follow back to back.
  task automatic send_word(nsps_pkg::op_e op, logic signed [15:0] c [9]);
    while (chance_idle()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    {in_ch.ax, in_ch.ay, in_ch.az} <= {c[0], c[1], c[2]};
    {in_ch.bx, in_ch.by, in_ch.bz} <= {c[3], c[4], c[5]};
    {in_ch.px, in_ch.py, in_ch.pz} <= {c[6], c[7], c[8]};
    do @(posedge clk_i); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic send_random(nsps_pkg::op_e op);
    logic signed [15:0] c [9];
    foreach (c[k]) c[k] = rand_coord();
    send_word(op, c);
  endtask

  task automatic send_coords(nsps_pkg::op_e op, int v0, int v1, int v2, int v3, int v4,
                             int v5);
    logic signed [15:0] c [9];
    foreach (c[k]) c[k] = 16'($urandom);
    if (op == nsps_pkg::OP_QUERY) begin
      c[6] = 16'(v0); c[7] = 16'(v1); c[8] = 16'(v2);
    end else begin
      c[0] = 16'(v0); c[1] = 16'(v1); c[2] = 16'(v2);
      c[3] = 16'(v3); c[4] = 16'(v4); c[5] = 16'(v5);
    end
    send_word(op, c);
  endtask

  // Drop valid and wait until every expected answer has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int n_seg;
    idle_enable = 1'b1;
    words_sent = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = nsps_pkg::OP_CLEAR;
    {in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by, in_ch.bz} = '0;
    {in_ch.px, in_ch.py, in_ch.pz} = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, zero-length segment, extreme coordinates, ties,
    // unused code, clear.
    send_coords(nsps_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0);
    send_coords(nsps_pkg::OP_APPEND, 5, 5, 5, 5, 5, 5);
    send_coords(nsps_pkg::OP_QUERY, -32768, 32767, 0, 0, 0, 0);
    send_coords(nsps_pkg::OP_APPEND, -32768, -32768, -32768, 32767, 32767, 32767);
    send_coords(nsps_pkg::OP_APPEND, 32767, 32767, 32767, -32768, -32768, -32768);
    send_coords(nsps_pkg::OP_QUERY, 32767, 32767, 32767, 0, 0, 0);
    send_coords(nsps_pkg::OP_QUERY, -32768, -32768, -32768, 0, 0, 0);
    send_coords(nsps_pkg::OP_QUERY, 32767, -32768, 100, 0, 0, 0);
    send_coords(nsps_pkg::OP_APPEND, 0, 0, 0, 1000, 0, 0);
    send_coords(nsps_pkg::OP_APPEND, 0, 0, 0, 1000, 0, 0);
    send_coords(nsps_pkg::OP_QUERY, 333, 7, 0, 0, 0, 0);
    send_coords(nsps_pkg::OP_QUERY, -50, 0, 0, 0, 0, 0);
    send_coords(nsps_pkg::OP_QUERY, 2000, 0, 0, 0, 0, 0);
    send_random(nsps_pkg::OP_NONE);
    send_coords(nsps_pkg::OP_QUERY, 1, 1, 1, 0, 0, 0);
    send_coords(nsps_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_coords(nsps_pkg::OP_QUERY, 9, 9, 9, 0, 0, 0);
    wait_drained();

    // Fill the table to capacity so that appends past the end are ignored.
    idle_enable = 1'b0;
    for (int i = 0; i < MaxSegments + 3; i++) send_random(nsps_pkg::OP_APPEND);
    send_random(nsps_pkg::OP_QUERY);
    send_random(nsps_pkg::OP_QUERY);
    idle_enable = 1'b1;
    send_random(nsps_pkg::OP_CLEAR);

    // Random: small tables rebuilt often, a few queries each.
    while (words_sent < 580) begin
      n_seg = $urandom_range(8, 1);
      if ($urandom_range(9) == 0) send_random(nsps_pkg::OP_NONE);
      for (int i = 0; i < n_seg; i++) send_random(nsps_pkg::OP_APPEND);
      repeat ($urandom_range(6, 1)) send_random(nsps_pkg::OP_QUERY);
      if ($urandom_range(9) == 0) wait_drained();
      idle_enable = (words_sent % 300) > 60;
      if (table_count > 40 || $urandom_range(2) == 0) send_random(nsps_pkg::OP_CLEAR);
    end
    idle_enable = 1'b1;

    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("Covered %0d input words and %0d answers, including a full table,",
             words_sent, answers);
    $display("empty-table queries, zero-length segments and unused codes.");
    if (fail_count == 0) begin
      $display("tb_nearest_segment_point_search passed");
    end else begin
      $display("tb_nearest_segment_point_search failed");
    end
    $finish;
  end
endmodule

### sim.f
rtl/core/nsps_pkg.sv
rtl/core/nsps_if.sv
rtl/core/nsps_div.sv
rtl/core/nsps_eval.sv
rtl/core/nearest_segment_point_search.sv
tb/nsps_checker.sv
tb/tb_nearest_segment_point_search.sv
